>>> rtl/core/rrts_pkg.sv
// Shared types and codes for the round-robin task scheduler.
// No dependencies; every other file but rrts_ram refers to it by scoped names.
package rrts_pkg;

  localparam logic [3:0] REQ_CREATE  = 4'd0;
  localparam logic [3:0] REQ_SLEEP   = 4'd1;
  localparam logic [3:0] REQ_EXIT    = 4'd2;
  localparam logic [3:0] REQ_WAITPID = 4'd3;
  localparam logic [3:0] REQ_SCHED   = 4'd4;
  localparam logic [3:0] REQ_HOLD    = 4'd5;
  localparam logic [3:0] REQ_RELEASE = 4'd6;
  localparam logic [3:0] REQ_GETPID  = 4'd7;
  localparam logic [3:0] REQ_PURGE   = 4'd8;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [2:0] STAT_FULL      = 3'd2;
  localparam logic [2:0] STAT_HELD      = 3'd3;
  localparam logic [2:0] STAT_NONE      = 3'd4;

  localparam logic [1:0] MODE_RUN    = 2'd0;
  localparam logic [1:0] MODE_SLEEP  = 2'd1;
  localparam logic [1:0] MODE_EXIT   = 2'd2;
  localparam logic [1:0] MODE_ZOMBIE = 2'd3;

  localparam logic [7:0] HOLD_MAX = 8'hFF;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [31:0] now_ms;
    logic [31:0] duration_ms;
    logic [7:0]  exit_code;
    logic [15:0] target_pid;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] pid_out;
    logic [8:0]  wait_status;
    logic [15:0] running_pid;
    logic        running_valid;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_DRAIN,
    S_COMMIT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    SK_SCHED,
    SK_WAIT,
    SK_CREATE
  } scan_kind_t;

  typedef struct packed {
    logic       clear;
    logic       vld;
    logic       used;
    logic       bounded;
    scan_kind_t kind;
  } scan_ctl_t;

  typedef struct packed {
    logic       below_found;
    logic       all_found;
    logic       free_found;
    logic [1:0] hit_mode;
    logic [7:0] hit_code;
  } scan_res_t;

endpackage

>>> rtl/core/rrts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/rrts_scan.sv
// Slot sweep evaluator: tracks best candidate keys and the first free slot
// as slot entries stream out of the task RAM. Depends on rrts_pkg.
module rrts_scan #(
  parameter int MAX_TASKS = 16,
  parameter int PID_BITS  = 16,
  localparam int IDX_W = $clog2(MAX_TASKS),
  localparam int KEY_W = PID_BITS + IDX_W,
  localparam int DW    = PID_BITS + 34
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rrts_pkg::scan_ctl_t ctl,
  input  logic [IDX_W-1:0]   chk_idx,
  input  logic [DW-1:0]      rd_data,
  input  logic [KEY_W-1:0]   start_key,
  input  logic [31:0]        now_ms,
  input  logic [15:0]        target_pid,
  output rrts_pkg::scan_res_t res,
  output logic [KEY_W-1:0]   below_key,
  output logic [KEY_W-1:0]   all_key,
  output logic [IDX_W-1:0]   free_idx
);

  logic [PID_BITS-1:0] pid;
  logic [1:0]          mode;
  logic [31:0]         value;
  logic [KEY_W-1:0]    key;
  logic                runnable;
  logic                cand;
  logic                is_below;

  logic             below_found_r, all_found_r, free_found_r;
  logic [KEY_W-1:0] below_key_r, all_key_r;
  logic [IDX_W-1:0] free_idx_r;
  logic [1:0]       hit_mode_r;
  logic [7:0]       hit_code_r;

  assign pid   = rd_data[DW-1 -: PID_BITS];
  assign mode  = rd_data[33:32];
  assign value = rd_data[31:0];
  assign key   = {pid, chk_idx};

  always_comb begin
    runnable = (mode == rrts_pkg::MODE_RUN) ||
               ((mode == rrts_pkg::MODE_SLEEP) && (value <= now_ms));
    case (ctl.kind)
      rrts_pkg::SK_SCHED: cand = ctl.used && runnable;
      rrts_pkg::SK_WAIT:  cand = ctl.used && (32'(pid) == 32'(target_pid));
      default:            cand = 1'b0;
    endcase
    is_below = ctl.bounded && (key < start_key);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      below_found_r <= 1'b0;
      all_found_r   <= 1'b0;
      free_found_r  <= 1'b0;
    end else if (ctl.vld) begin
      if (cand && (!all_found_r || key > all_key_r)) begin
        all_found_r <= 1'b1;
        all_key_r   <= key;
        hit_mode_r  <= mode;
        hit_code_r  <= value[7:0];
      end
      if (cand && is_below && (!below_found_r || key > below_key_r)) begin
        below_found_r <= 1'b1;
        below_key_r   <= key;
      end
      if (!ctl.used && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= chk_idx;
      end
    end
  end

  assign res.below_found = below_found_r;
  assign res.all_found   = all_found_r;
  assign res.free_found  = free_found_r;
  assign res.hit_mode    = hit_mode_r;
  assign res.hit_code    = hit_code_r;
  assign below_key       = below_key_r;
  assign all_key         = all_key_r;
  assign free_idx        = free_idx_r;

endmodule

>>> rtl/core/rrts_ctrl.sv
// Request sequencer: slot valid bits, current task, pid counter, hold depth,
// RAM access order and result fields. Depends on rrts_pkg.
module rrts_ctrl #(
  parameter int MAX_TASKS = 16,
  parameter int PID_BITS  = 16,
  localparam int IDX_W = $clog2(MAX_TASKS),
  localparam int KEY_W = PID_BITS + IDX_W,
  localparam int DW    = PID_BITS + 34
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rrts_pkg::in_t       in_data,
  output logic                res_valid,
  input  logic                res_ready,
  output rrts_pkg::out_t      res,
  output logic                wr_en,
  output logic [IDX_W-1:0]    wr_addr,
  output logic [DW-1:0]       wr_data,
  output logic                rd_en,
  output logic [IDX_W-1:0]    rd_addr,
  output rrts_pkg::scan_ctl_t scan_ctl,
  output logic [IDX_W-1:0]    chk_idx,
  output logic [KEY_W-1:0]    start_key,
  output logic [31:0]         scan_now,
  output logic [15:0]         scan_target,
  input  rrts_pkg::scan_res_t scan_res,
  input  logic [KEY_W-1:0]    below_key,
  input  logic [KEY_W-1:0]    all_key,
  input  logic [IDX_W-1:0]    free_idx
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);

  rrts_pkg::state_t     state_r, state_nxt;
  rrts_pkg::in_t        req_r;
  rrts_pkg::scan_kind_t kind_r, kind_nxt;
  logic                 bounded_r, bounded_nxt;
  logic [MAX_TASKS-1:0] used_r, used_nxt;
  logic [IDX_W-1:0]     cur_idx_r, cur_idx_nxt;
  logic                 cur_vld_r, cur_vld_nxt;
  logic [PID_BITS-1:0]  cur_pid_r, cur_pid_nxt;
  logic [PID_BITS-1:0]  pid_cnt_r, pid_cnt_nxt;
  logic [7:0]           hold_r, hold_nxt;
  logic [IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 chk_vld_r;
  logic [IDX_W-1:0]     chk_idx_r;
  logic [2:0]           stat_r, stat_nxt;
  logic [15:0]          pido_r, pido_nxt;
  logic [8:0]           wst_r, wst_nxt;
  logic [KEY_W-1:0]     pick_key;
  logic [31:0]          cur_pid32;
  logic [31:0]          cnt_pid32;
  logic                 sched_req;
  logic                 scan_clear;

  assign cur_pid32 = 32'(cur_pid_r);
  assign cnt_pid32 = 32'(pid_cnt_r);
  assign pick_key  = scan_res.below_found ? below_key : all_key;

  always_comb begin
    sched_req = (req_r.req_type == rrts_pkg::REQ_SLEEP) ||
                (req_r.req_type == rrts_pkg::REQ_EXIT)  ||
                (req_r.req_type == rrts_pkg::REQ_SCHED) ||
                (req_r.req_type == rrts_pkg::REQ_PURGE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rrts_pkg::S_IDLE;
      used_r    <= '0;
      cur_idx_r <= '0;
      cur_vld_r <= 1'b0;
      pid_cnt_r <= '0;
      hold_r    <= '0;
      chk_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      cur_idx_r <= cur_idx_nxt;
      cur_vld_r <= cur_vld_nxt;
      pid_cnt_r <= pid_cnt_nxt;
      hold_r    <= hold_nxt;
      chk_vld_r <= (state_r == rrts_pkg::S_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    kind_r    <= kind_nxt;
    bounded_r <= bounded_nxt;
    cur_pid_r <= cur_pid_nxt;
    rd_idx_r  <= rd_idx_nxt;
    chk_idx_r <= rd_idx_r;
    stat_r    <= stat_nxt;
    pido_r    <= pido_nxt;
    wst_r     <= wst_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    bounded_nxt = bounded_r;
    used_nxt    = used_r;
    cur_idx_nxt = cur_idx_r;
    cur_vld_nxt = cur_vld_r;
    cur_pid_nxt = cur_pid_r;
    pid_cnt_nxt = pid_cnt_r;
    hold_nxt    = hold_r;
    rd_idx_nxt  = rd_idx_r;
    stat_nxt    = stat_r;
    pido_nxt    = pido_r;
    wst_nxt     = wst_r;
    wr_en       = 1'b0;
    wr_addr     = cur_idx_r;
    wr_data     = '0;
    rd_en       = 1'b0;
    rd_addr     = rd_idx_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    scan_clear  = 1'b0;

    case (state_r)
      rrts_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = rrts_pkg::S_PREP;
        end
      end

      rrts_pkg::S_PREP: begin
        stat_nxt       = rrts_pkg::STAT_OK;
        pido_nxt       = '0;
        wst_nxt        = '0;
        rd_idx_nxt     = '0;
        scan_clear     = 1'b1;
        bounded_nxt    = cur_vld_r;
        state_nxt      = rrts_pkg::S_DONE;
        case (req_r.req_type)
          rrts_pkg::REQ_SLEEP: begin
            wr_en   = cur_vld_r;
            wr_data = {cur_pid_r, rrts_pkg::MODE_SLEEP,
                       req_r.now_ms + req_r.duration_ms};
          end
          rrts_pkg::REQ_EXIT: begin
            wr_en   = cur_vld_r;
            wr_data = {cur_pid_r, rrts_pkg::MODE_EXIT, 32'(req_r.exit_code)};
          end
          rrts_pkg::REQ_PURGE: begin
            if (cur_vld_r) begin
              used_nxt[cur_idx_r] = 1'b0;
              cur_vld_nxt         = 1'b0;
            end
          end
          rrts_pkg::REQ_WAITPID: begin
            pido_nxt  = req_r.target_pid;
            kind_nxt  = rrts_pkg::SK_WAIT;
            state_nxt = rrts_pkg::S_SCAN;
          end
          rrts_pkg::REQ_CREATE: begin
            kind_nxt  = rrts_pkg::SK_CREATE;
            state_nxt = rrts_pkg::S_SCAN;
          end
          rrts_pkg::REQ_HOLD: begin
            if (hold_r != rrts_pkg::HOLD_MAX) begin
              hold_nxt = hold_r + 8'd1;
            end
          end
          rrts_pkg::REQ_RELEASE: begin
            if (hold_r != '0) begin
              hold_nxt = hold_r - 8'd1;
            end
          end
          rrts_pkg::REQ_GETPID: begin
            pido_nxt = cur_vld_r ? cur_pid32[15:0] : 16'd0;
          end
          default: begin
          end
        endcase
        if (sched_req) begin
          kind_nxt = rrts_pkg::SK_SCHED;
          if (hold_r != '0) begin
            stat_nxt = rrts_pkg::STAT_HELD;
          end else begin
            state_nxt = rrts_pkg::S_SCAN;
          end
        end
      end

      rrts_pkg::S_SCAN: begin
        rd_en      = 1'b1;
        rd_idx_nxt = rd_idx_r + IDX_W'(1);
        if (rd_idx_r == LAST_IDX) begin
          state_nxt = rrts_pkg::S_DRAIN;
        end
      end

      rrts_pkg::S_DRAIN: begin
        state_nxt = rrts_pkg::S_COMMIT;
      end

      rrts_pkg::S_COMMIT: begin
        state_nxt = rrts_pkg::S_DONE;
        case (kind_r)
          rrts_pkg::SK_SCHED: begin
            if (scan_res.below_found || scan_res.all_found) begin
              wr_en       = 1'b1;
              wr_addr     = pick_key[IDX_W-1:0];
              wr_data     = {pick_key[KEY_W-1 -: PID_BITS], rrts_pkg::MODE_RUN, 32'd0};
              cur_idx_nxt = pick_key[IDX_W-1:0];
              cur_pid_nxt = pick_key[KEY_W-1 -: PID_BITS];
              cur_vld_nxt = 1'b1;
            end else begin
              cur_vld_nxt = 1'b0;
              stat_nxt    = rrts_pkg::STAT_NONE;
            end
          end
          rrts_pkg::SK_WAIT: begin
            if (!scan_res.all_found) begin
              stat_nxt = rrts_pkg::STAT_NOT_FOUND;
            end else if (scan_res.hit_mode == rrts_pkg::MODE_EXIT) begin
              wst_nxt = {1'b1, scan_res.hit_code};
              wr_en   = 1'b1;
              wr_addr = all_key[IDX_W-1:0];
              wr_data = {all_key[KEY_W-1 -: PID_BITS], rrts_pkg::MODE_ZOMBIE,
                         32'(scan_res.hit_code)};
            end
          end
          default: begin
            if (scan_res.free_found) begin
              wr_en              = 1'b1;
              wr_addr            = free_idx;
              wr_data            = {pid_cnt_r, rrts_pkg::MODE_RUN, 32'd0};
              used_nxt[free_idx] = 1'b1;
              pido_nxt           = cnt_pid32[15:0];
              pid_cnt_nxt        = pid_cnt_r + PID_BITS'(1);
            end else begin
              stat_nxt = rrts_pkg::STAT_FULL;
            end
          end
        endcase
      end

      rrts_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = rrts_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = rrts_pkg::S_IDLE;
      end
    endcase
  end

  assign scan_ctl.clear   = scan_clear;
  assign scan_ctl.vld     = chk_vld_r;
  assign scan_ctl.used    = used_r[chk_idx_r];
  assign scan_ctl.bounded = bounded_r;
  assign scan_ctl.kind    = kind_r;
  assign chk_idx          = chk_idx_r;
  assign start_key        = {cur_pid_r, cur_idx_r};
  assign scan_now         = req_r.now_ms;
  assign scan_target      = req_r.target_pid;

  assign res.status        = stat_r;
  assign res.pid_out       = pido_r;
  assign res.wait_status   = wst_r;
  assign res.running_pid   = cur_vld_r ? cur_pid32[15:0] : 16'd0;
  assign res.running_valid = cur_vld_r;

endmodule

>>> rtl/core/round_robin_task_scheduler_top.sv
// Create, waitpid, and sleep, exit, schedule and purge while the hold depth is zero,
// make one sweep of the task RAM (one read a cycle) between input accept and result;
// every other request goes from its prep state straight to the result. One item at a time: the
// next item can be accepted in the cycle after the result enters the output register.
// Reset: synchronous, active low; clears slot valid bits, current task, pid
// counter and hold depth at once. Slot RAM contents need no clearing.
module round_robin_task_scheduler_top #(
  parameter int MAX_TASKS = 16,
  parameter int PID_BITS  = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rrts_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rrts_pkg::out_t out_data
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int KEY_W = PID_BITS + IDX_W;
  localparam int DW    = PID_BITS + 34;

  logic                wr_en, rd_en;
  logic [IDX_W-1:0]    wr_addr, rd_addr, chk_idx, free_idx;
  logic [DW-1:0]       wr_data, rd_data;
  rrts_pkg::scan_ctl_t scan_ctl;
  rrts_pkg::scan_res_t scan_res;
  logic [KEY_W-1:0]    start_key, below_key, all_key;
  logic [31:0]         scan_now;
  logic [15:0]         scan_target;
  logic                res_valid, res_ready;
  rrts_pkg::out_t      res;
  logic                out_valid_r;
  rrts_pkg::out_t      out_data_r;

  rrts_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_TASKS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rrts_scan #(
    .MAX_TASKS (MAX_TASKS),
    .PID_BITS  (PID_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .chk_idx    (chk_idx),
    .rd_data    (rd_data),
    .start_key  (start_key),
    .now_ms     (scan_now),
    .target_pid (scan_target),
    .res        (scan_res),
    .below_key  (below_key),
    .all_key    (all_key),
    .free_idx   (free_idx)
  );

  rrts_ctrl #(
    .MAX_TASKS (MAX_TASKS),
    .PID_BITS  (PID_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .scan_ctl    (scan_ctl),
    .chk_idx     (chk_idx),
    .start_key   (start_key),
    .scan_now    (scan_now),
    .scan_target (scan_target),
    .scan_res    (scan_res),
    .below_key   (below_key),
    .all_key     (all_key),
    .free_idx    (free_idx)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
